/* rtl/form_field_extract_url_decode_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the form field extractor
// Shared concurrent-assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FORM_FIELD_EXTRACT_URL_DECODE_MACROS_SVH
`define FORM_FIELD_EXTRACT_URL_DECODE_MACROS_SVH

// same-cycle implication
`define FFUD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffud: same-cycle check failed");

// next-cycle implication
`define FFUD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffud: next-cycle check failed");

`endif

/* rtl/ffud_pkg.sv */
// ----------------------------------------------------------------------------
// ffud_pkg
// Types, codes and helpers shared by the form field extractor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffud_pkg;

  localparam int KEY_MAX_BYTES_DEF = 8;
  localparam int VALUE_MAX_DEF     = 1023;
  localparam int RES_MAX           = 4;
  localparam int RES_CNT_W         = 3;

  // register indexes
  localparam logic [1:0] REG_KEY_CHARS  = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_VALUE  = 2'd2;

  localparam logic [9:0] MAX_VALUE_RESET = 10'd64;

  // characters with a role in the body syntax
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic ITEM_VALUE   = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  typedef enum logic [3:0] {
    PH_KEY   = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HEX1 = 3'b100
  } esc_t;

  typedef struct packed {
    logic [63:0] key_chars;
    logic [3:0]  key_length;
    logic [9:0]  max_value_length;
  } cfg_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] value_byte;
    logic       key_found;
    logic [9:0] raw_length;
    logic       run_last;
  } result_t;

  typedef result_t [RES_MAX-1:0] res_list_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61) v = c - 8'h57;
    else v = c - 8'h37;
    return v[3:0];
  endfunction

  function automatic result_t mk_value(input logic [7:0] b);
    result_t r;
    r.item_kind  = ITEM_VALUE;
    r.value_byte = b;
    r.key_found  = 1'b0;
    r.raw_length = '0;
    r.run_last   = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_summary(input logic found, input logic [9:0] len);
    result_t r;
    r.item_kind  = ITEM_SUMMARY;
    r.value_byte = '0;
    r.key_found  = found;
    r.raw_length = len;
    r.run_last   = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/ffud_core.sv */
// ----------------------------------------------------------------------------
// ffud_core
// Parser state and single-pass decode of one body byte into up to four results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffud_core import ffud_pkg::*; #(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
  parameter int VALUE_MAX     = VALUE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output res_list_t            res_list,
  output logic [RES_CNT_W-1:0] res_count
);

  localparam int LimCap = (VALUE_MAX > 1023) ? 1023 : VALUE_MAX;

  phase_t     ph, ph_next;
  logic [3:0] kp, kp_next;
  logic [9:0] cc, cc_next;
  esc_t       esc, esc_next;
  logic [7:0] pend, pend_next;
  logic       found, found_next;
  logic       stopped, stopped_next;

  logic [3:0]           klen;
  logic [9:0]           limit;
  logic [7:0]           key_byte;
  logic                 do_plain;
  logic [RES_CNT_W-1:0] n;
  logic [1:0]           last_idx;
  res_list_t            list;

  // effective limits
  assign klen  = (cfg.key_length > 4'(KEY_MAX_BYTES)) ? 4'(KEY_MAX_BYTES) : cfg.key_length;
  assign limit = (cfg.max_value_length > 10'(LimCap)) ? 10'(LimCap) : cfg.max_value_length;
  assign key_byte = cfg.key_chars[{kp[2:0], 3'b000} +: 8];

  // next state and result list for the byte in the input register
  always_comb begin
    ph_next      = ph;
    kp_next      = kp;
    cc_next      = cc;
    esc_next     = esc;
    pend_next    = pend;
    found_next   = found;
    stopped_next = stopped;
    n            = '0;
    list         = '0;
    do_plain     = 1'b0;
    last_idx     = '0;

    if (stopped) begin
      // skip to the byte marked last, which just clears
      if (in_last) begin
        ph_next      = PH_KEY;
        kp_next      = '0;
        cc_next      = '0;
        esc_next     = ESC_NONE;
        pend_next    = '0;
        found_next   = 1'b0;
        stopped_next = 1'b0;
      end
    end else begin
      if (in_byte != CH_NUL) begin
        unique case (ph)
          PH_KEY: begin
            if (in_byte == CH_AMP) begin
              kp_next = '0;
            end else if (kp < klen) begin
              if (in_byte == key_byte) kp_next = kp + 4'd1;
              else ph_next = PH_SKIP;
            end else begin
              ph_next = (in_byte == CH_EQ) ? PH_VALUE : PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (in_byte == CH_AMP) begin
              ph_next = PH_KEY;
              kp_next = '0;
            end
          end
          PH_VALUE: begin
            if (in_byte == CH_AMP) begin
              if (found) begin
                // end of the selected value: flush a pending escape
                if (esc == ESC_PCT) begin
                  list[n[1:0]] = mk_value(CH_PCT);
                  n = n + 3'd1;
                end else if (esc == ESC_HEX1) begin
                  list[n[1:0]] = mk_value(CH_PCT);
                  n = n + 3'd1;
                  list[n[1:0]] = mk_value(pend);
                  n = n + 3'd1;
                end
                esc_next  = ESC_NONE;
                pend_next = '0;
                ph_next   = PH_DONE;
              end else begin
                ph_next = PH_KEY;
                kp_next = '0;
              end
            end else begin
              found_next = 1'b1;
              if (cc < limit) begin
                cc_next = cc + 10'd1;
                // escape decode
                unique case (esc)
                  ESC_PCT: begin
                    if (hex_ok(in_byte)) begin
                      pend_next = in_byte;
                      esc_next  = ESC_HEX1;
                    end else begin
                      list[n[1:0]] = mk_value(CH_PCT);
                      n = n + 3'd1;
                      esc_next = ESC_NONE;
                      do_plain = 1'b1;
                    end
                  end
                  ESC_HEX1: begin
                    if (hex_ok(in_byte)) begin
                      list[n[1:0]] = mk_value({hex_nib(pend), hex_nib(in_byte)});
                      n = n + 3'd1;
                    end else begin
                      list[n[1:0]] = mk_value(CH_PCT);
                      n = n + 3'd1;
                      list[n[1:0]] = mk_value(pend);
                      n = n + 3'd1;
                      do_plain = 1'b1;
                    end
                    esc_next  = ESC_NONE;
                    pend_next = '0;
                  end
                  default: do_plain = 1'b1;
                endcase
                // plain byte
                if (do_plain) begin
                  if (in_byte == CH_PLUS) begin
                    list[n[1:0]] = mk_value(CH_SPACE);
                    n = n + 3'd1;
                  end else if (in_byte == CH_PCT) begin
                    esc_next = ESC_PCT;
                  end else begin
                    list[n[1:0]] = mk_value(in_byte);
                    n = n + 3'd1;
                  end
                end
                // limit reached: give a pending escape literally
                if (cc_next >= limit) begin
                  if (esc_next == ESC_PCT) begin
                    list[n[1:0]] = mk_value(CH_PCT);
                    n = n + 3'd1;
                  end else if (esc_next == ESC_HEX1) begin
                    list[n[1:0]] = mk_value(CH_PCT);
                    n = n + 3'd1;
                    list[n[1:0]] = mk_value(pend_next);
                    n = n + 3'd1;
                  end
                  esc_next  = ESC_NONE;
                  pend_next = '0;
                end
              end
            end
          end
          default: ;
        endcase
      end

      // end of body: flush, summary, clear
      if (in_byte == CH_NUL || in_last) begin
        if (esc_next == ESC_PCT) begin
          list[n[1:0]] = mk_value(CH_PCT);
          n = n + 3'd1;
        end else if (esc_next == ESC_HEX1) begin
          list[n[1:0]] = mk_value(CH_PCT);
          n = n + 3'd1;
          list[n[1:0]] = mk_value(pend_next);
          n = n + 3'd1;
        end
        list[n[1:0]] = mk_summary(found_next, cc_next);
        n = n + 3'd1;
        ph_next      = PH_KEY;
        kp_next      = '0;
        cc_next      = '0;
        esc_next     = ESC_NONE;
        pend_next    = '0;
        found_next   = 1'b0;
        stopped_next = !in_last;
      end

      // mark the final result of this byte
      if (n != '0) begin
        last_idx = 2'(n - 3'd1);
        list[last_idx].run_last = 1'b1;
      end
    end
  end

  assign res_list  = list;
  assign res_count = n;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      ph      <= PH_KEY;
      kp      <= '0;
      cc      <= '0;
      esc     <= ESC_NONE;
      pend    <= '0;
      found   <= 1'b0;
      stopped <= 1'b0;
    end else if (fire) begin
      ph      <= ph_next;
      kp      <= kp_next;
      cc      <= cc_next;
      esc     <= esc_next;
      pend    <= pend_next;
      found   <= found_next;
      stopped <= stopped_next;
    end
  end

endmodule

/* rtl/ffud_res_buf.sv */
// ----------------------------------------------------------------------------
// ffud_res_buf
// Result register bank: holds the results of one byte and sends them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "form_field_extract_url_decode_macros.svh"

module ffud_res_buf import ffud_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [RES_CNT_W-1:0] load_count,
  input  res_list_t            load_list,
  output logic                 free,
  output logic                 m_valid,
  input  logic                 m_ready,
  output result_t              m_item
);

  res_list_t            items;
  logic [RES_CNT_W-1:0] cnt;
  logic                 take;

  assign m_valid = (cnt != '0);
  assign m_item  = items[0];
  assign take    = m_valid && m_ready;
  // empty, or the last result leaves in this cycle
  assign free    = (cnt == '0) || ((cnt == 3'd1) && m_ready);

  // result count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= load_count;
    end else if (take) begin
      cnt <= cnt - 3'd1;
    end
  end

  // payload: load, or shift toward the head on each transfer
  always_ff @(posedge clk) begin
    if (load) begin
      items <= load_list;
    end else if (take) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        items[i] <= items[i+1];
      end
    end
  end

  `FFUD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= 3'(RES_MAX))
  `FFUD_ASSERT_NOW(a_load_when_free, load, free && load_count != '0)
  `FFUD_ASSERT_NEXT(a_drain_empty, take && cnt == 3'd1 && !load, !m_valid)
  `FFUD_ASSERT_NEXT(a_load_shows, load, m_valid && cnt == $past(load_count))

endmodule

/* rtl/form_field_extract_url_decode.sv */
// Path: a body byte is held in the input register, then its results in the result
// register; the byte waits in the input register while the result bank is not free.
// Throughput: one byte per cycle while m_tready is high and each byte gives at most
// one result; a byte with more results holds the single output port until all leave.
// Reset: synchronous rst clears the parser and the result bank, and sets the
// registers to key_chars 0, key_length 0, max_value_length 64.
// ----------------------------------------------------------------------------
// form_field_extract_url_decode
// Extracts and percent-decodes one field of a urlencoded form body stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module form_field_extract_url_decode import ffud_pkg::*; #(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
  parameter int VALUE_MAX     = VALUE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // body input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] body_byte
  input  logic        s_tlast,   // body_last
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] value_byte, [8] key_found, [18:9] raw_length
  output logic        m_tuser,   // item_kind
  output logic        m_tlast,   // run_last
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t                 cfg;
  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 in_last;
  logic                 buf_free;
  logic                 core_fire;
  res_list_t            res_list;
  logic [RES_CNT_W-1:0] res_count;
  result_t              m_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_chars        <= '0;
      cfg.key_length       <= '0;
      cfg.max_value_length <= MAX_VALUE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_CHARS:  cfg.key_chars        <= cfg_data;
        REG_KEY_LENGTH: cfg.key_length       <= cfg_data[3:0];
        REG_MAX_VALUE:  cfg.max_value_length <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // input register
  assign core_fire = in_valid && buf_free;
  assign s_tready  = !in_valid || core_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ffud_core #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES),
    .VALUE_MAX    (VALUE_MAX)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fire     (core_fire),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .res_list (res_list),
    .res_count(res_count)
  );

  ffud_res_buf u_res_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (core_fire && (res_count != '0)),
    .load_count(res_count),
    .load_list (res_list),
    .free      (buf_free),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_item    (m_item)
  );

  // output packing
  assign m_tdata = {5'b0, m_item.raw_length, m_item.key_found, m_item.value_byte};
  assign m_tuser = m_item.item_kind;
  assign m_tlast = m_item.run_last;

endmodule
